// ----- design/i2a_pkg.sv -----
`default_nettype none

package i2a_pkg;

    // port widths fixed by the interface
    localparam int FUNC_W = 2;
    localparam int IN_W   = 32;
    localparam int CHAR_W = 8;

    localparam int VALUE_WIDTH_DEFAULT = 32;

    // conversion modes
    localparam logic [FUNC_W-1:0] FUNC_SIGNED_DEC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNSIGNED_DEC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEX          = 2'd2;
    // bit 1 of the mode selects hexadecimal, so mode three acts as hex
    localparam int FUNC_HEX_BIT = 1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [3:0]        DIGIT_MAX  = 4'd9;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic load;
        logic step;
        logic count;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic is_hex;
        logic minus;
        logic step_last;
        logic digit_last;
    } t_status;

    // decimal digits of 2**w - 1, 1233/4096 approximates log10(2)
    function automatic int dec_digits(input int w);
        return (w * 1233) / 4096 + 1;
    endfunction

    function automatic int store_depth(input int w);
        int dec;
        int hex;
        dec = dec_digits(w);
        hex = (w + 3) / 4;
        return (dec > hex) ? dec : hex;
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input t_digit d);
        logic [CHAR_W-1:0] code;
        if (d > DIGIT_MAX) begin
            code = CHAR_A + CHAR_W'(d) - CHAR_W'(DIGIT_MAX + 4'd1);
        end else begin
            code = CHAR_ZERO + CHAR_W'(d);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- design/integer_to_ascii_converter.sv -----
`default_nettype none

// Converts one number to ASCII, most significant character first. A transaction
// is taken when start is high and busy is low; the characters then appear on
// o_character, one per cycle, each valid for the single cycle that o_strobe is
// high, with o_last on the final one. The receiver cannot stall and must take
// every character as it comes. Decimal modes run a shift-add-3 loop that
// handles four bits per cycle; hex skips the loop, its digits being loaded
// directly. A count step then finds the leading digit, after which the
// characters follow, the minus sign included. A number has at most 11
// characters at the default width; the next start is taken in the cycle the
// final character shows on the outputs.
module integer_to_ascii_converter #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire logic [i2a_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [i2a_pkg::IN_W-1:0]    i_value,
    output logic                             busy,
    output logic                             o_strobe,
    output logic [i2a_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last
);

    i2a_pkg::t_cmd    cmd;
    i2a_pkg::t_status status;

    i2a_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    i2a_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ----- design/i2a_ctrl.sv -----
`default_nettype none

module i2a_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire i2a_pkg::t_status i_status,
    output i2a_pkg::t_cmd         o_cmd,
    output logic                  busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                // hex digits are already in place after the load
                if (i_status.is_hex) begin
                    n_state = S_COUNT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.step_last) begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = i_status.minus ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_DIGIT;
            end
            S_DIGIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.digit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_digit && i_status.digit_last |=> !busy)
        else $error("busy held after final character");

endmodule

`default_nettype wire

// ----- design/i2a_datapath.sv -----
`default_nettype none

module i2a_datapath #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [i2a_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [i2a_pkg::IN_W-1:0]     i_value,
    input  wire i2a_pkg::t_cmd                i_cmd,
    output i2a_pkg::t_status                  o_status,
    output logic                              o_strobe,
    output logic [i2a_pkg::CHAR_W-1:0]        o_character,
    output logic                              o_last
);

    // magnitude padded to whole nibbles, four bits converted per step
    localparam int MAG_W  = ((VALUE_WIDTH + 3) / 4) * 4;
    localparam int NIB    = MAG_W / 4;
    localparam int DEPTH  = i2a_pkg::store_depth(VALUE_WIDTH);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int STEP_W = $clog2(NIB);

    i2a_pkg::t_digit             r_store [DEPTH];
    i2a_pkg::t_digit             n_store [DEPTH];
    logic [MAG_W-1:0]            r_shift;
    logic [MAG_W-1:0]            n_shift;
    logic                        r_hex;
    logic                        n_hex;
    logic                        r_minus;
    logic                        n_minus;
    logic [STEP_W-1:0]           r_step;
    logic [STEP_W-1:0]           n_step;
    logic [IDX_W-1:0]            r_index;
    logic [IDX_W-1:0]            n_index;
    logic                        r_strobe;
    logic                        n_strobe;
    logic [i2a_pkg::CHAR_W-1:0]  r_char;
    logic [i2a_pkg::CHAR_W-1:0]  n_char;
    logic                        r_last;
    logic                        n_last;

    logic [VALUE_WIDTH+i2a_pkg::IN_W-1:0] w_ext;
    logic [VALUE_WIDTH-1:0]      w_val;
    logic                        w_neg;
    logic [VALUE_WIDTH-1:0]      w_abs;
    logic [MAG_W-1:0]            w_mag;
    i2a_pkg::t_digit             w_bcd [DEPTH];
    logic [MAG_W-1:0]            w_shift;
    logic [IDX_W-1:0]            w_top;

    // take the low VALUE_WIDTH bits, zero above the input width
    assign w_ext = {{VALUE_WIDTH{1'b0}}, i_value};
    assign w_val = w_ext[VALUE_WIDTH-1:0];
    assign w_neg = (i_func == i2a_pkg::FUNC_SIGNED_DEC) && w_val[VALUE_WIDTH-1];
    assign w_abs = w_neg ? (~w_val + VALUE_WIDTH'(1)) : w_val;
    assign w_mag = MAG_W'(w_abs);

    // four shift-add-3 steps per cycle
    always_comb begin
        w_bcd   = r_store;
        w_shift = r_shift;
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (w_bcd[i] >= 4'd5) begin
                    w_bcd[i] = w_bcd[i] + 4'd3;
                end
            end
            for (int i = DEPTH - 1; i > 0; i--) begin
                w_bcd[i] = {w_bcd[i][2:0], w_bcd[i-1][3]};
            end
            w_bcd[0] = {w_bcd[0][2:0], w_shift[MAG_W-1]};
            w_shift  = w_shift << 1;
        end
    end

    // index of the leading nonzero digit, zero when all digits are zero
    always_comb begin
        w_top = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_store[i] != 4'd0) begin
                w_top = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_store  = r_store;
        n_shift  = r_shift;
        n_hex    = r_hex;
        n_minus  = r_minus;
        n_step   = r_step;
        n_index  = r_index;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        if (i_cmd.load) begin
            n_hex   = i_func[i2a_pkg::FUNC_HEX_BIT];
            n_minus = w_neg;
            n_step  = '0;
            n_shift = w_mag;
            for (int i = 0; i < DEPTH; i++) begin
                n_store[i] = 4'd0;
            end
            if (i_func[i2a_pkg::FUNC_HEX_BIT]) begin
                for (int i = 0; i < NIB; i++) begin
                    n_store[i] = w_mag[4*i +: 4];
                end
            end
        end else if (i_cmd.step) begin
            n_store = w_bcd;
            n_shift = w_shift;
            n_step  = r_step + STEP_W'(1);
        end else if (i_cmd.count) begin
            n_index = w_top;
        end else if (i_cmd.emit_sign) begin
            n_strobe = 1'b1;
            n_char   = i2a_pkg::CHAR_MINUS;
            n_last   = 1'b0;
        end else if (i_cmd.emit_digit) begin
            n_strobe = 1'b1;
            n_char   = i2a_pkg::ascii_of(r_store[r_index]);
            n_last   = (r_index == '0);
            n_index  = r_index - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex    <= 1'b0;
            r_minus  <= 1'b0;
            r_step   <= '0;
            r_index  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_hex    <= n_hex;
            r_minus  <= n_minus;
            r_step   <= n_step;
            r_index  <= n_index;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_shift <= n_shift;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_status.is_hex     = r_hex;
    assign o_status.minus      = r_minus;
    assign o_status.step_last  = (r_step == STEP_W'(NIB - 1));
    assign o_status.digit_last = (r_index == '0);
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("character right after final character");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_character == i2a_pkg::CHAR_MINUS) |-> !o_last)
        else $error("minus sign marked as final character");

    a_sign_needs_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sign |-> r_minus)
        else $error("minus emitted for non-negative value");

endmodule

`default_nettype wire

// ----- sim/integer_to_ascii_converter_checker.sv -----
`timescale 1ns / 1ps

module integer_to_ascii_converter_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [i2a_pkg::FUNC_W-1:0]   i_func,
    input  logic [i2a_pkg::IN_W-1:0]     i_value,
    input  logic                         o_strobe,
    input  logic [i2a_pkg::CHAR_W-1:0]   o_character,
    input  logic                         o_last,
    output int                           fail_count,
    output int                           pending_chars
);

    localparam int FUNC_W = i2a_pkg::FUNC_W;
    localparam int IN_W   = i2a_pkg::IN_W;
    localparam int CHAR_W = i2a_pkg::CHAR_W;

    // each entry holds {character, last}
    logic [CHAR_W:0] expected_chars[$];

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        if (d > i2a_pkg::DIGIT_MAX) begin
            return i2a_pkg::CHAR_A + CHAR_W'(d - (i2a_pkg::DIGIT_MAX + 4'd1));
        end
        return i2a_pkg::CHAR_ZERO + CHAR_W'(d);
    endfunction

    // queue the characters of one number, most significant first
    function automatic void predict_chars(input logic [FUNC_W-1:0] mode,
                                          input logic [IN_W-1:0] value);
        logic [IN_W-1:0] magnitude;
        logic [IN_W-1:0] base;
        logic            negative;
        logic [3:0]      digits[0:15];
        int              n;
        int              k;
        negative  = (mode == i2a_pkg::FUNC_SIGNED_DEC) && value[IN_W-1];
        magnitude = negative ? (~value + 1'b1) : value;
        base      = mode[i2a_pkg::FUNC_HEX_BIT] ? 32'd16 : 32'd10;
        n = 0;
        do begin
            digits[n] = 4'(magnitude % base);
            magnitude = magnitude / base;
            n++;
        end while (magnitude != 0);
        if (negative) begin
            expected_chars.push_back({i2a_pkg::CHAR_MINUS, 1'b0});
        end
        for (k = n - 1; k >= 0; k--) begin
            expected_chars.push_back({digit_char(digits[k]), k == 0});
        end
    endfunction

    always @(posedge i_clk) begin
        logic [CHAR_W:0] want;
        if (!i_rst_n) begin
            fail_count <= 0;
            expected_chars.delete();
        end else begin
            if (o_strobe) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character %h last %b", $time,
                             o_character, o_last);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (want[CHAR_W:1] !== o_character || want[0] !== o_last) begin
                        $display({"%0t: mismatch expected char %h last %b,",
                                  " actual char %h last %b"},
                                 $time, want[CHAR_W:1], want[0], o_character, o_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                predict_chars(i_func, i_value);
            end
        end
        pending_chars <= expected_chars.size();
    end

endmodule

// ----- sim/integer_to_ascii_converter_tb.sv -----
`timescale 1ns / 1ps

module integer_to_ascii_converter_tb;

    localparam int FUNC_W = i2a_pkg::FUNC_W;
    localparam int IN_W   = i2a_pkg::IN_W;
    localparam int CHAR_W = i2a_pkg::CHAR_W;

    // bit 1 set, so this mode converts as hex
    localparam logic [FUNC_W-1:0] FUNC_HEX_ALIAS = 2'd3;

    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT  = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic [FUNC_W-1:0] i_func;
    logic [IN_W-1:0]   i_value;
    logic              busy;
    logic              o_strobe;
    logic [CHAR_W-1:0] o_character;
    logic              o_last;
    int                fail_count;
    int                pending_chars;
    int                quiet_cycles = 0;

    integer_to_ascii_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_func      (i_func),
        .i_value     (i_value),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    integer_to_ascii_converter_checker char_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_character   (o_character),
        .o_last        (o_last),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on cycles with no transaction and no character
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic convert(input logic [FUNC_W-1:0] mode,
                           input logic [IN_W-1:0] value);
        start   <= 1'b1;
        i_func  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start   <= 1'b0;
            i_func  <= FUNC_W'($urandom);
            i_value <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_chars != 0);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 14);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_W-1:0] random_value();
        logic [IN_W-1:0] p;
        int              i;
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'h1 << $urandom_range(0, 31);
            3: begin
                // around a power of ten, where the digit count changes
                p = 1;
                for (i = $urandom_range(0, 9); i > 0; i--) p = p * 10;
                return p + $urandom_range(0, 2) - 1;
            end
            4: return -$urandom_range(1, 1000);
            5: begin
                p = 32'h1 << (4 * $urandom_range(0, 7));
                return p + $urandom_range(0, 2) - 1;
            end
            default: return {1'b1, 31'($urandom)};
        endcase
    endfunction

    initial begin
        int  i;
        bit  burst;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_func  = '0;
        i_value = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        convert(i2a_pkg::FUNC_SIGNED_DEC, 32'h0);
        convert(i2a_pkg::FUNC_UNSIGNED_DEC, 32'h0);
        convert(i2a_pkg::FUNC_HEX, 32'h0);
        convert(FUNC_HEX_ALIAS, 32'h0);
        convert(i2a_pkg::FUNC_SIGNED_DEC, 32'hffff_ffff);
        convert(i2a_pkg::FUNC_UNSIGNED_DEC, 32'hffff_ffff);
        convert(i2a_pkg::FUNC_HEX, 32'hffff_ffff);
        convert(FUNC_HEX_ALIAS, 32'hffff_ffff);
        pause(5);
        convert(i2a_pkg::FUNC_SIGNED_DEC, 32'h8000_0000);
        convert(i2a_pkg::FUNC_UNSIGNED_DEC, 32'h8000_0000);
        convert(i2a_pkg::FUNC_HEX, 32'h8000_0000);
        convert(FUNC_HEX_ALIAS, 32'h8000_0000);
        convert(i2a_pkg::FUNC_SIGNED_DEC, 32'h7fff_ffff);
        convert(i2a_pkg::FUNC_HEX, 32'h7fff_ffff);
        convert(i2a_pkg::FUNC_SIGNED_DEC, 32'd1);
        convert(i2a_pkg::FUNC_UNSIGNED_DEC, 32'd9);
        convert(i2a_pkg::FUNC_UNSIGNED_DEC, 32'd10);
        convert(i2a_pkg::FUNC_HEX, 32'd15);
        convert(FUNC_HEX_ALIAS, 32'd16);
        convert(i2a_pkg::FUNC_HEX, 32'hdead_beef);
        convert(i2a_pkg::FUNC_UNSIGNED_DEC, 32'd999_999_999);
        convert(i2a_pkg::FUNC_SIGNED_DEC, 32'd1_000_000_000);
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            // every third stretch of 40 transactions runs back to back
            burst = ((i / 40) % 3) == 1;
            convert(FUNC_W'($urandom_range(0, 3)), random_value());
            if (!burst) begin
                pause(random_gap());
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
